>>> rtl/core/assert_macros.svh
// Assertion helpers shared by the core; all checks are clocked on aclk
// and KST_ASSERT checks are held off while aresetn is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define KST_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error("core assertion failed");
`define KST_ASSERT_ALWAYS(lbl, prop) \
    lbl: assert property (@(posedge aclk) prop) else $error("core assertion failed");
`else
`define KST_ASSERT(lbl, prop)
`define KST_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

>>> rtl/core/kst_pkg.sv
package kst_pkg;
    localparam int DEF_TABLE_ROWS = 64;
    localparam int DEF_TABLE_COLS = 512;
    localparam int QUEUE_DEPTH    = 2;

    // work codes handed from front to back
    typedef enum logic [1:0] {
        OP_WRITE,
        OP_TWO,
        OP_TABLE,
        OP_KRON
    } op_t;

    // configuration register indexes
    localparam logic [0:0] CFG_ROWS = 1'b0;
    localparam logic [0:0] CFG_COLS = 1'b1;

    // symbol codes
    localparam logic [1:0] SYM_ZERO = 2'b00;
    localparam logic [1:0] SYM_POS  = 2'b01;
    localparam logic [1:0] SYM_NEG  = 2'b11;

    function automatic int addr_bits(input int depth);
        return (depth > 1) ? $clog2(depth) : 1;
    endfunction
endpackage

>>> rtl/core/kst_ram.sv
module kst_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 2
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end
endmodule

>>> rtl/core/kst_queue.sv
module kst_queue import kst_pkg::*; #(
    parameter int WIDTH = 8
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             not_full,
    input  logic             pop,
    output logic             not_empty,
    output logic [WIDTH-1:0] pop_data
);
    localparam int PW = addr_bits(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    logic [WIDTH-1:0] slot_reg [QUEUE_DEPTH];
    logic [PW-1:0]    wptr_reg;
    logic [PW-1:0]    rptr_reg;
    logic [CW-1:0]    count_reg;

    assign not_full  = (count_reg != CW'(QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign pop_data  = slot_reg[rptr_reg];

    // store entries and advance pointers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end else begin
            if (push) begin
                slot_reg[wptr_reg] <= push_data;
                wptr_reg <= (wptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : wptr_reg + 1'b1;
            end
            if (pop) begin
                rptr_reg <= (rptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : rptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end
endmodule

>>> rtl/core/kst_front.sv
module kst_front import kst_pkg::*; #(
    parameter int TABLE_ROWS = DEF_TABLE_ROWS,
    parameter int TABLE_COLS = DEF_TABLE_COLS,
    parameter int AW = addr_bits(TABLE_ROWS * TABLE_COLS)
) (
    input  logic          s_valid,
    output logic          s_ready,
    input  logic          s_kind,
    input  logic [5:0]    s_row_index,
    input  logic [8:0]    s_col_index,
    input  logic          s_residue_bit,
    input  logic [63:0]   s_numerator,
    input  logic [62:0]   s_odd_prime,
    input  logic [31:0]   s_prime_position,
    input  logic [6:0]    rows_in_use,
    input  logic          q_not_full,
    output logic          q_push,
    output op_t           q_op,
    output logic          q_bit,
    output logic [63:0]   q_d,
    output logic [62:0]   q_p,
    output logic [AW-1:0] q_idx
);
    logic        in_rows;
    logic        is_two;
    logic        two_pos;
    logic        tbl_ok;
    logic        wr_ok;
    logic [31:0] waddr;
    logic [31:0] trow;

    // classify the request
    always_comb begin
        in_rows = (s_prime_position != 32'd0) && (s_prime_position < {25'd0, rows_in_use});
        is_two  = (s_odd_prime == 63'd2) && s_numerator[0];
        two_pos = (s_numerator[2:0] == 3'd1) || (s_numerator[2:0] == 3'd7);
        tbl_ok  = (s_prime_position <= 32'(TABLE_ROWS)) && (s_odd_prime != 63'd0);
        wr_ok   = ({26'd0, s_row_index} < 32'(TABLE_ROWS))
               && ({23'd0, s_col_index} < 32'(TABLE_COLS));
        waddr   = {26'd0, s_row_index} * 32'(TABLE_COLS) + {23'd0, s_col_index};
        trow    = s_prime_position - 32'd1;
        if (!s_kind) begin
            q_op = OP_WRITE;
        end else if (!in_rows) begin
            q_op = OP_KRON;
        end else if (is_two) begin
            q_op = OP_TWO;
        end else if (!tbl_ok) begin
            q_op = OP_KRON;
        end else begin
            q_op = OP_TABLE;
        end
    end

    // drop out-of-range table writes, queue the rest
    assign s_ready = q_not_full;
    assign q_push  = s_valid && q_not_full && (s_kind || wr_ok);
    assign q_bit   = s_kind ? two_pos : s_residue_bit;
    assign q_d     = s_numerator;
    assign q_p     = s_odd_prime;
    assign q_idx   = s_kind ? trow[AW-1:0] : waddr[AW-1:0];
endmodule

>>> rtl/core/kst_back.sv
`include "assert_macros.svh"
module kst_back import kst_pkg::*; #(
    parameter int TABLE_ROWS = DEF_TABLE_ROWS,
    parameter int TABLE_COLS = DEF_TABLE_COLS,
    parameter int AW = addr_bits(TABLE_ROWS * TABLE_COLS)
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          q_valid,
    output logic          q_pop,
    input  op_t           q_op,
    input  logic          q_bit,
    input  logic [63:0]   q_d,
    input  logic [62:0]   q_p,
    input  logic [AW-1:0] q_idx,
    input  logic [9:0]    cols_in_use,
    output logic          m_valid,
    input  logic          m_ready,
    output logic [1:0]    m_symbol,
    output logic          m_used_table,
    output logic          m_column_overflow
);
    typedef enum logic [2:0] {
        ST_IDLE, ST_STRIP, ST_DIV, ST_FIX, ST_JAC, ST_TCHK, ST_RDW, ST_DONE
    } state_t;

    state_t        state_reg;
    op_t           op_reg;
    logic          dneg_reg;
    logic [2:0]    dlo_reg;
    logic [63:0]   mag_reg;
    logic [63:0]   r_reg;
    logic [62:0]   n_reg;
    logic [5:0]    cnt_reg;
    logic          neg_reg;
    logic          vpar_reg;
    logic [AW-1:0] row_reg;
    logic [1:0]    sym_reg;
    logic          used_reg;
    logic          ovf_reg;
    logic          m_valid_reg;
    logic [1:0]    m_symbol_reg;
    logic          m_used_reg;
    logic          m_ovf_reg;

    logic [63:0]   r_shift;
    logic [63:0]   r_step;
    logic [64:0]   jdiff;
    logic [31:0]   lim;
    logic [31:0]   taddr;
    logic          rd_en;
    logic          rdata;
    logic          out_free;

    // one restoring division step and table address
    always_comb begin
        r_shift = {r_reg[62:0], mag_reg[63]};
        r_step  = (r_shift >= {1'b0, n_reg}) ? r_shift - {1'b0, n_reg} : r_shift;
        jdiff   = {1'b0, r_reg} - {2'b0, n_reg};
        lim     = ({22'd0, cols_in_use} < 32'(TABLE_COLS)) ? {22'd0, cols_in_use}
                                                           : 32'(TABLE_COLS);
        taddr   = 32'(row_reg) * 32'(TABLE_COLS) + r_reg[31:0] - 32'd1;
        rd_en   = (state_reg == ST_TCHK) && (r_reg != 64'd0) && (r_reg <= {32'd0, lim});
    end

    assign q_pop    = (state_reg == ST_IDLE) && q_valid;
    assign out_free = !m_valid_reg || m_ready;

    kst_ram #(
        .WIDTH(1),
        .DEPTH(TABLE_ROWS * TABLE_COLS)
    ) u_table (
        .aclk  (aclk),
        .we    (q_pop && (q_op == OP_WRITE)),
        .waddr (q_idx),
        .wdata (q_bit),
        .re    (rd_en),
        .raddr (taddr[AW-1:0]),
        .rdata (rdata)
    );

    // sequence one request at a time
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            // drop the result once taken, unless a new one is loaded below
            if (m_ready && (state_reg != ST_DONE)) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (q_valid) begin
                        op_reg   <= q_op;
                        row_reg  <= q_idx;
                        dneg_reg <= q_d[63];
                        dlo_reg  <= q_d[2:0];
                        mag_reg  <= q_d[63] ? 64'd0 - q_d : q_d;
                        n_reg    <= q_p;
                        r_reg    <= 64'd0;
                        cnt_reg  <= 6'd0;
                        neg_reg  <= 1'b0;
                        vpar_reg <= 1'b0;
                        used_reg <= 1'b0;
                        ovf_reg  <= 1'b0;
                        unique case (q_op)
                            OP_WRITE: state_reg <= ST_IDLE;
                            OP_TWO: begin
                                sym_reg   <= q_bit ? SYM_POS : SYM_NEG;
                                state_reg <= ST_DONE;
                            end
                            OP_TABLE: state_reg <= ST_DIV;
                            OP_KRON: begin
                                if (q_p == 63'd0) begin
                                    sym_reg <= ((q_d == 64'd1) || (q_d == '1)) ? SYM_POS
                                                                              : SYM_ZERO;
                                    state_reg <= ST_DONE;
                                end else if (!q_p[0]) begin
                                    if (!q_d[0]) begin
                                        sym_reg   <= SYM_ZERO;
                                        state_reg <= ST_DONE;
                                    end else begin
                                        state_reg <= ST_STRIP;
                                    end
                                end else begin
                                    state_reg <= ST_DIV;
                                end
                            end
                            default: state_reg <= ST_IDLE;
                        endcase
                    end
                end
                ST_STRIP: begin
                    // remove factors of two from the bottom argument
                    if (n_reg[0]) begin
                        neg_reg   <= vpar_reg && (dlo_reg != 3'd1) && (dlo_reg != 3'd7);
                        state_reg <= ST_DIV;
                    end else begin
                        n_reg    <= n_reg >> 1;
                        vpar_reg <= !vpar_reg;
                    end
                end
                ST_DIV: begin
                    r_reg   <= r_step;
                    mag_reg <= mag_reg << 1;
                    cnt_reg <= cnt_reg + 6'd1;
                    if (cnt_reg == 6'd63) begin
                        state_reg <= ST_FIX;
                    end
                end
                ST_FIX: begin
                    // fold a negative top argument to a non-negative remainder
                    if (dneg_reg && (r_reg != 64'd0)) begin
                        r_reg <= {1'b0, n_reg} - r_reg;
                    end
                    state_reg <= (op_reg == OP_TABLE) ? ST_TCHK : ST_JAC;
                end
                ST_JAC: begin
                    if (r_reg == 64'd0) begin
                        sym_reg   <= (n_reg == 63'd1) ? (neg_reg ? SYM_NEG : SYM_POS)
                                                      : SYM_ZERO;
                        state_reg <= ST_DONE;
                    end else if (!r_reg[0]) begin
                        r_reg <= r_reg >> 1;
                        if ((n_reg[2:0] == 3'd3) || (n_reg[2:0] == 3'd5)) begin
                            neg_reg <= !neg_reg;
                        end
                    end else if (jdiff[64]) begin
                        // swap by reciprocity, then subtract
                        r_reg <= {1'b0, n_reg} - r_reg;
                        n_reg <= r_reg[62:0];
                        if ((r_reg[1:0] == 2'd3) && (n_reg[1:0] == 2'd3)) begin
                            neg_reg <= !neg_reg;
                        end
                    end else begin
                        r_reg <= jdiff[63:0];
                    end
                end
                ST_TCHK: begin
                    if (r_reg == 64'd0) begin
                        sym_reg   <= SYM_ZERO;
                        state_reg <= ST_DONE;
                    end else if (r_reg > {32'd0, lim}) begin
                        sym_reg   <= SYM_ZERO;
                        ovf_reg   <= 1'b1;
                        state_reg <= ST_DONE;
                    end else begin
                        state_reg <= ST_RDW;
                    end
                end
                ST_RDW: begin
                    sym_reg   <= rdata ? SYM_POS : SYM_NEG;
                    used_reg  <= 1'b1;
                    state_reg <= ST_DONE;
                end
                ST_DONE: begin
                    // hand the result to the output register
                    if (out_free) begin
                        m_valid_reg  <= 1'b1;
                        m_symbol_reg <= sym_reg;
                        m_used_reg   <= used_reg;
                        m_ovf_reg    <= ovf_reg;
                        state_reg    <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_symbol          = m_symbol_reg;
    assign m_used_table      = m_used_reg;
    assign m_column_overflow = m_ovf_reg;

    `KST_ASSERT(a_rdw_after_tchk, (state_reg == ST_RDW) |-> ($past(state_reg) == ST_TCHK))
    `KST_ASSERT(a_result_from_done, $rose(m_valid_reg) |-> ($past(state_reg) == ST_DONE))
    `KST_ASSERT(a_jac_odd_bottom, (state_reg == ST_JAC) |-> n_reg[0])
    `KST_ASSERT(a_div_rem_below, (state_reg == ST_DIV) |-> (r_reg < {1'b0, n_reg}))
endmodule

>>> rtl/core/kronecker_symbol_table_unit_core.sv
// Channel   Handshake              Payload
// s_ (in)   s_valid / s_ready      kind, row/col index, residue bit, d, prime, position
// m_ (out)  m_valid / m_ready      symbol, used_table, column_overflow
// cfg       cfg_valid / cfg_ready  cfg_index, cfg_data
//
// Table write: taken in the back end's idle state; prime-two rule: idle, done, output register.
// Table query: the 64-step bit-serial remainder unit, then a fix-up, a range check and a table
// read (no table read for a zero remainder or a column overflow).
// Iterative query: 64 remainder steps plus one step per factor of two in the
// prime plus at most about two shift or subtract steps per bit of remainder and
// prime together.
// Reset clears control only; the residue table holds garbage until written.
// A two-entry queue lets the input side keep accepting while the back end works.
module kronecker_symbol_table_unit_core import kst_pkg::*; #(
    parameter int TABLE_ROWS = DEF_TABLE_ROWS,
    parameter int TABLE_COLS = DEF_TABLE_COLS
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_kind,
    input  logic [5:0]  s_row_index,
    input  logic [8:0]  s_col_index,
    input  logic        s_residue_bit,
    input  logic [63:0] s_numerator,
    input  logic [62:0] s_odd_prime,
    input  logic [31:0] s_prime_position,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_symbol,
    output logic        m_used_table,
    output logic        m_column_overflow,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [0:0]  cfg_index,
    input  logic [9:0]  cfg_data
);
    localparam int AW = addr_bits(TABLE_ROWS * TABLE_COLS);
    localparam int QW = 2 + 1 + 64 + 63 + AW;

    logic [6:0]    rows_reg;
    logic [9:0]    cols_reg;
    logic          f_push;
    op_t           f_op;
    logic          f_bit;
    logic [63:0]   f_d;
    logic [62:0]   f_p;
    logic [AW-1:0] f_idx;
    logic          q_not_full;
    logic          q_not_empty;
    logic          q_pop;
    logic [QW-1:0] q_data;

    // hold configuration registers
    assign cfg_ready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rows_reg <= 7'd64;
            cols_reg <= 10'd512;
        end else if (cfg_valid) begin
            if (cfg_index == CFG_ROWS) begin
                rows_reg <= cfg_data[6:0];
            end else if (cfg_index == CFG_COLS) begin
                cols_reg <= cfg_data;
            end
        end
    end

    kst_front #(
        .TABLE_ROWS(TABLE_ROWS),
        .TABLE_COLS(TABLE_COLS),
        .AW        (AW)
    ) u_front (
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_kind          (s_kind),
        .s_row_index     (s_row_index),
        .s_col_index     (s_col_index),
        .s_residue_bit   (s_residue_bit),
        .s_numerator     (s_numerator),
        .s_odd_prime     (s_odd_prime),
        .s_prime_position(s_prime_position),
        .rows_in_use     (rows_reg),
        .q_not_full      (q_not_full),
        .q_push          (f_push),
        .q_op            (f_op),
        .q_bit           (f_bit),
        .q_d             (f_d),
        .q_p             (f_p),
        .q_idx           (f_idx)
    );

    kst_queue #(
        .WIDTH(QW)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (f_push),
        .push_data({f_op, f_bit, f_d, f_p, f_idx}),
        .not_full (q_not_full),
        .pop      (q_pop),
        .not_empty(q_not_empty),
        .pop_data (q_data)
    );

    kst_back #(
        .TABLE_ROWS(TABLE_ROWS),
        .TABLE_COLS(TABLE_COLS),
        .AW        (AW)
    ) u_back (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .q_valid          (q_not_empty),
        .q_pop            (q_pop),
        .q_op             (op_t'(q_data[QW-1 -: 2])),
        .q_bit            (q_data[QW-3]),
        .q_d              (q_data[QW-4 -: 64]),
        .q_p              (q_data[AW+62 -: 63]),
        .q_idx            (q_data[AW-1:0]),
        .cols_in_use      (cols_reg),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_symbol         (m_symbol),
        .m_used_table     (m_used_table),
        .m_column_overflow(m_column_overflow)
    );
endmodule
